[hw/rtl/signed_int_to_decimal_ascii_macros.svh]
// assertion macros shared by the decimal text converter
// no dependencies; included by the top level only
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SIDA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sida: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define SIDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sida: next-cycle check failed");

`endif

[hw/rtl/sida_pkg.sv]
// shared types and constants for the signed integer to decimal text converter
// no dependencies
package sida_pkg;

    localparam int MAG_W      = 32;
    localparam int NUM_DIGITS = 10;
    localparam int CHAR_W     = 6;
    localparam int BIT_CNT_W  = $clog2(MAG_W);
    localparam int NDIG_W     = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;

    typedef logic [3:0] digit_t;

    // one command for the whole row of digit cells
    typedef struct packed {
        logic clear;
        logic bit_shift;
        logic dig_shift;
    } cell_ctl_t;

endpackage

[hw/rtl/sida_cell.sv]
// one bcd digit cell of the shift-add-3 chain
// depends on sida_pkg
module sida_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  sida_pkg::cell_ctl_t ctl,
    input  logic              bit_in,
    input  sida_pkg::digit_t  digit_in,
    output logic              bit_out,
    output sida_pkg::digit_t  digit
);
    import sida_pkg::*;

    digit_t digit_reg;
    digit_t digit_next;
    digit_t adj;

    // add 3 before the doubling so the digit carries at ten
    assign adj     = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign bit_out = adj[3];
    assign digit   = digit_reg;

    always_comb begin
        digit_next = digit_reg;
        if (ctl.clear) begin
            digit_next = '0;
        end else if (ctl.bit_shift) begin
            digit_next = {adj[2:0], bit_in};
        end else if (ctl.dig_shift) begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_reg <= '0;
        end else begin
            digit_reg <= digit_next;
        end
    end

endmodule

[hw/rtl/sida_ctrl.sv]
// sequencer: input capture, magnitude shifter, digit emission and output register
// depends on sida_pkg; drives the row of sida_cell instances
module sida_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [sida_pkg::MAG_W-1:0] s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sida_pkg::CHAR_W-1:0]   m_char_code,
    output logic                          m_last,
    output sida_pkg::cell_ctl_t           cell_ctl,
    output logic                          ser_bit,
    input  sida_pkg::digit_t              top_digit
);
    import sida_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SKIP = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [MAG_W-1:0]     mag_reg, mag_next;
    logic                 neg_reg, neg_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [NDIG_W-1:0]    ndig_reg, ndig_next;
    logic                 m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic                 last_reg, last_next;
    logic [MAG_W-1:0]     raw;
    logic                 out_free;

    assign raw         = s_value;
    assign out_free    = !m_valid_reg || m_ready;
    assign s_ready     = (state_reg == ST_IDLE);
    assign ser_bit     = mag_reg[MAG_W-1];
    assign m_valid     = m_valid_reg;
    assign m_char_code = char_reg;
    assign m_last      = last_reg;

    always_comb begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        bit_cnt_next = bit_cnt_reg;
        ndig_next    = ndig_reg;
        m_valid_next = m_valid_reg && !m_ready;
        char_next    = char_reg;
        last_next    = last_reg;
        cell_ctl     = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    neg_next       = raw[MAG_W-1];
                    mag_next       = raw[MAG_W-1] ? (~raw + 1'b1) : raw;
                    bit_cnt_next   = '0;
                    cell_ctl.clear = 1'b1;
                    state_next     = ST_CONV;
                end
            end
            ST_CONV: begin
                cell_ctl.bit_shift = 1'b1;
                mag_next     = {mag_reg[MAG_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BIT_CNT_W'(MAG_W - 1)) begin
                    ndig_next  = NDIG_W'(NUM_DIGITS);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // drop leading zeros, keep at least one digit
                if (top_digit == '0 && ndig_reg != NDIG_W'(1)) begin
                    cell_ctl.dig_shift = 1'b1;
                    ndig_next = ndig_reg - 1'b1;
                end else begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    char_next    = CHAR_MINUS;
                    last_next    = 1'b0;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    char_next          = CHAR_ZERO + CHAR_W'(top_digit);
                    last_next          = (ndig_reg == NDIG_W'(1));
                    cell_ctl.dig_shift = 1'b1;
                    ndig_next          = ndig_reg - 1'b1;
                    if (ndig_reg == NDIG_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        bit_cnt_reg <= bit_cnt_next;
        ndig_reg    <= ndig_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

endmodule

[hw/rtl/signed_int_to_decimal_ascii.sv]
// Signed 32-bit integer to decimal ASCII text, one character per output beat.
// Input channel s_ (valid/ready) carries s_value; output channel m_ carries
// m_char_code and m_last. Clock aclk, synchronous active-low reset aresetn.
// A negative number starts with '-'; no leading zeros; zero gives one '0';
// m_last is high on the final character of each number.
// The magnitude is shifted one bit per cycle through a row of ten bcd cells
// (shift-add-3). Leading zero digits are then dropped, and characters leave
// one per cycle while the receiver accepts them.
// s_ready is high only while idle; one number is in flight at a time.
// A stalled receiver holds the output register and pauses the digit
// sequencer; nothing is lost or repeated.
// Reset returns to idle with no output beat pending.
// Depends on sida_pkg, sida_cell, sida_ctrl and the macros header.
`include "signed_int_to_decimal_ascii_macros.svh"

module signed_int_to_decimal_ascii (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [sida_pkg::MAG_W-1:0] s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sida_pkg::CHAR_W-1:0]       m_char_code,
    output logic                              m_last
);
    import sida_pkg::*;

    cell_ctl_t              cell_ctl;
    logic                   ser_bit;
    logic [NUM_DIGITS-1:0]  cell_carry;
    digit_t                 cell_digit [NUM_DIGITS];

    sida_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_code (m_char_code),
        .m_last      (m_last),
        .cell_ctl    (cell_ctl),
        .ser_bit     (ser_bit),
        .top_digit   (cell_digit[NUM_DIGITS-1])
    );

    // cell 0 is the ones digit; carries and digits move toward the top cell
    for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
        if (i == 0) begin : g_first
            sida_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctl      (cell_ctl),
                .bit_in   (ser_bit),
                .digit_in (4'd0),
                .bit_out  (cell_carry[i]),
                .digit    (cell_digit[i])
            );
        end else begin : g_rest
            sida_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctl      (cell_ctl),
                .bit_in   (cell_carry[i-1]),
                .digit_in (cell_digit[i-1]),
                .bit_out  (cell_carry[i]),
                .digit    (cell_digit[i])
            );
        end
    end

    `SIDA_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)
    `SIDA_ASSERT_SAME(a_char_range, aclk, aresetn, m_valid, (m_char_code == CHAR_MINUS) || (m_char_code >= CHAR_ZERO && m_char_code <= CHAR_NINE))
    `SIDA_ASSERT_SAME(a_sign_not_last, aclk, aresetn, m_valid && (m_char_code == CHAR_MINUS), !m_last)
    `SIDA_ASSERT_SAME(a_no_overflow, aclk, aresetn, cell_ctl.bit_shift, !cell_carry[NUM_DIGITS-1])

endmodule
